// File: src/assert_macros.svh
// Assertion macros shared by the RTL files of the strided offset block.
// Every macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/stoff_pkg.sv
// Shared widths, codes and divider handshake types for the strided offset block.
// No dependencies; the interfaces, the RTL and the bench import it.
package stoff_pkg;

    localparam int IDX_W      = 48;   // linear index and offset
    localparam int DIM_W      = 32;   // extent and stride
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int DIV_STEPS  = 48;
    localparam int DIV_CNT_W  = 6;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XLATE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTIG    = 1'd1;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quotient;
        logic [DIM_W-1:0] remainder;
    } t_div_rsp;

endpackage

// File: src/stoff_in_if.sv
// Input channel of the strided offset block: valid/ready plus request word.
// Depends on stoff_pkg.
interface stoff_in_if;
    import stoff_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [SEL_W-1:0] dim_select;
    logic [DIM_W-1:0] dim_extent;
    logic [DIM_W-1:0] dim_stride;
    logic [IDX_W-1:0] linear_index;

    modport source (
        output valid, req_type, dim_select, dim_extent, dim_stride, linear_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, dim_select, dim_extent, dim_stride, linear_index,
        output ready
    );
endinterface

// File: src/stoff_out_if.sv
// Output channel of the strided offset block: valid/ready plus offset word.
// Depends on stoff_pkg.
interface stoff_out_if;
    import stoff_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] element_offset;

    modport source (
        output valid, element_offset,
        input  ready
    );
    modport sink (
        input  valid, element_offset,
        output ready
    );
endinterface

// File: src/stoff_div.sv
// Radix-2 restoring divider, 48-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on stoff_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stoff_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stoff_pkg::t_div_req i_req,
    output stoff_pkg::t_div_rsp o_rsp
);
    import stoff_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]     r_q;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_div;

    logic [DIM_W:0]       w_shift;
    logic [DIM_W:0]       w_diff;
    logic                 w_take;

    assign w_shift = {r_rem, r_q[IDX_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_take  = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low bits hold it
            r_rem <= w_take ? w_diff[DIM_W-1:0] : w_shift[DIM_W-1:0];
            r_q   <= {r_q[IDX_W-2:0], w_take};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

    `ASSERT_IMPL(a_div_no_restart, i_req.start, !r_busy, "divider started while busy")
    `ASSERT_IMPL(a_div_rem_bound, r_done, r_rem < r_div, "remainder not below divisor")
    `ASSERT_NEXT(a_div_done_pulse, r_done, !r_done, "done held for two cycles")
endmodule

// File: src/strided_tensor_offset.sv
// Strided tensor offset: a load returns nothing. A translate in contiguous mode, or
// with no dimensions in use, goes straight to the push state. Otherwise each
// dimension in use takes a table read, the 48-step shared divider, two passes through
// the shared 32x32 multiplier and an accumulate; a zero extent skips the divider.
// One item at a time. Sync active-low reset sets dim_count to 1, contiguous_mode to 0;
// the extent and stride tables are not reset.
`include "assert_macros.svh"

module strided_tensor_offset #(
    parameter int MAX_DIMS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    stoff_in_if.sink                           i_in,
    stoff_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [stoff_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stoff_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import stoff_pkg::*;

    localparam int         TAB_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [4:0] MAX_N = 5'(MAX_DIMS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL0  = 3'd4;
    localparam logic [2:0] S_MUL1  = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    logic [DIM_W-1:0] ext_tab [MAX_DIMS];
    logic [DIM_W-1:0] str_tab [MAX_DIMS];

    logic [2:0]       r_state,     n_state;
    logic [TAB_W-1:0] r_dim,       n_dim;
    logic [IDX_W-1:0] r_rest,      n_rest;
    logic [IDX_W-1:0] r_coord,     n_coord;
    logic [63:0]      r_prod,      n_prod;
    logic [IDX_W-1:0] r_acc,       n_acc;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_data,  n_out_data;
    logic [3:0]       r_dim_count, n_dim_count;
    logic             r_contig,    n_contig;
    logic [DIM_W-1:0] r_ext;
    logic [DIM_W-1:0] r_str;

    logic [4:0]       w_dims;
    logic [DIM_W-1:0] w_mul_a;
    logic [63:0]      w_prod;
    logic             w_load;

    t_div_req div_req;
    t_div_rsp div_rsp;

    stoff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_load     = i_in.valid && (r_state == S_IDLE) && (i_in.req_type == REQ_LOAD)
                        && (5'(i_in.dim_select) < MAX_N);

    // saturate the dimension count to the table depth
    assign w_dims  = (5'(r_dim_count) > MAX_N) ? MAX_N : 5'(r_dim_count);

    // shared multiplier: low 32 coordinate bits first, then the top 16
    assign w_mul_a = (r_state == S_MUL0) ? r_coord[DIM_W-1:0]
                                         : {16'b0, r_coord[IDX_W-1:DIM_W]};
    assign w_prod  = w_mul_a * r_str;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            ext_tab[TAB_W'(i_in.dim_select)] <= i_in.dim_extent;
            str_tab[TAB_W'(i_in.dim_select)] <= i_in.dim_stride;
        end
        if (r_state == S_READ) begin
            r_ext <= ext_tab[r_dim];
            r_str <= str_tab[r_dim];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_rest      = r_rest;
        n_coord     = r_coord;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_dim_count = r_dim_count;
        n_contig    = r_contig;

        div_req.start    = 1'b0;
        div_req.dividend = r_rest;
        div_req.divisor  = r_ext;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_COUNT: n_dim_count = i_cfg_data[3:0];
                CFG_CONTIG:    n_contig    = i_cfg_data[0];
                default: ;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid && (i_in.req_type == REQ_XLATE)) begin
                    if (r_contig) begin
                        n_acc   = i_in.linear_index;
                        n_state = S_PUSH;
                    end else if (w_dims == 5'd0) begin
                        n_acc   = '0;
                        n_state = S_PUSH;
                    end else begin
                        n_rest  = i_in.linear_index;
                        n_acc   = '0;
                        n_dim   = TAB_W'(w_dims - 5'd1);
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_START;
            end
            S_START: begin
                if (r_ext == '0) begin
                    // zero extent: whole remainder is the coordinate
                    n_coord = r_rest;
                    n_rest  = '0;
                    n_state = S_MUL0;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_coord = {16'b0, div_rsp.remainder};
                    n_rest  = div_rsp.quotient;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_prod  = w_prod;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_acc   = r_acc + r_prod[IDX_W-1:0];
                n_prod  = w_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = r_acc + {r_prod[15:0], 32'b0};
                if (r_dim == '0) begin
                    n_state = S_PUSH;
                end else begin
                    n_dim   = r_dim - 1'b1;
                    n_state = S_READ;
                end
            end
            S_PUSH: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dim_count <= 4'd1;
            r_contig    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dim_count <= n_dim_count;
            r_contig    <= n_contig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim      <= n_dim;
        r_rest     <= n_rest;
        r_coord    <= n_coord;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.element_offset = r_out_data;

    `ASSERT_IMPL(a_done_in_div, div_rsp.done, r_state == S_DIV, "divider done outside wait state")
    `ASSERT_IMPL(a_out_from_push, $rose(r_out_valid), $past(r_state) == S_PUSH, "word not from push")
    `ASSERT_IMPL(a_coord_bound, $past(div_rsp.done), r_coord < IDX_W'(r_ext), "coord too large")
endmodule

// File: bench/strided_tensor_offset_tb.sv
// Self-checking bench for strided_tensor_offset: directed probe table, then
// randomized load/translate words under a series of register settings.
// Depends on stoff_pkg, stoff_in_if, stoff_out_if and the RTL top level.
`timescale 1ns / 100ps

module strided_tensor_offset_tb;
    import stoff_pkg::*;

    localparam int DIMS            = 8;
    localparam int SETTLE_CYCLES   = 4;     // a load is written to its table entry as it is taken
    localparam int DRAIN_CYCLES    = 450;   // covers the deepest translate
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 86;

    localparam logic [IDX_W-1:0] ALL_ONES = '1;

    // dimension count and pass-through setting used by each random phase
    localparam logic [3:0] PHASE_DIMS [NUM_PHASES] =
        '{4'd1, 4'd8, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd5, 4'd6, 4'd7, 4'd12, 4'd2};
    localparam logic PHASE_PASS [NUM_PHASES] =
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic             set_cfg;   // rewrite both registers before this word
        logic [3:0]       dims;
        logic             pass;
        logic             req;
        logic [SEL_W-1:0] sel;
        logic [DIM_W-1:0] extent;
        logic [DIM_W-1:0] stride;
        logic [IDX_W-1:0] index;
        logic             typed;     // offset column holds the answer
        logic [IDX_W-1:0] offset;
    } t_probe_row;

    localparam int NUM_PROBES = 21;
    localparam t_probe_row PROBES [NUM_PROBES] = '{
        // zero extent: the whole index becomes the coordinate
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd0, 32'h0000_0000, 32'h0000_0001, ALL_ONES, 1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          ALL_ONES, 1'b1, ALL_ONES},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000, 48'h0,    1'b1, 48'h0},
        // unit extent: coordinate is always zero; then the widest extent and an eight-dimension walk
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd0, 32'h0000_0001, 32'hFFFF_FFFF, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd5, 32'h0000_0000, 32'h0000_0000,
          48'h0003_0000_0039, 1'b1, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000,
          48'hFFFF_FFFF_FFFE, 1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd1, 32'h0000_0003, 32'h0000_0005, ALL_ONES, 1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd2, 32'h0000_0007, 32'h8000_0000, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd3, 32'h0000_0000, 32'h0000_0002, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd4, 32'h0000_0010, 32'h0000_0001, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd5, 32'h0001_0000, 32'hFFFF_FFFF, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd6, 32'h0000_0002, 32'h0000_0000, 48'h0,    1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_LOAD,  3'd7, 32'hFFFF_FFFF, 32'h0000_0003, 48'h0,    1'b0, 48'h0},
        '{1'b1, 4'd8, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000, ALL_ONES, 1'b0, 48'h0},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000, 48'h0,    1'b1, 48'h0},
        // no dimensions in use
        '{1'b1, 4'd0, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000, ALL_ONES, 1'b1, 48'h0},
        // count above the table size saturates, with and without pass-through
        '{1'b1, 4'd15, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000,
          48'h5555_AAAA_5555, 1'b0, 48'h0},
        '{1'b1, 4'd15, 1'b1, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000,
          ALL_ONES, 1'b1, ALL_ONES},
        '{1'b0, 4'd0, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000, 48'h0,    1'b1, 48'h0},
        '{1'b1, 4'd3, 1'b0, REQ_XLATE, 3'd0, 32'h0000_0000, 32'h0000_0000,
          48'h1234_5678_9ABC, 1'b0, 48'h0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stoff_in_if  req_ch ();
    stoff_out_if rsp_ch ();

    strided_tensor_offset dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the block's tables and registers
    logic [DIM_W-1:0] extent_shadow [DIMS];
    logic [DIM_W-1:0] stride_shadow [DIMS];
    logic [3:0]       dims_in_use;
    logic             passthrough;

    logic [IDX_W-1:0] pending_offsets [$];
    logic [IDX_W-1:0] want_offset;

    int mismatches = 0;
    int offsets_checked = 0;
    int loads_sent = 0;
    int translates_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    wire req_fire = req_ch.valid & req_ch.ready;
    wire rsp_fire = rsp_ch.valid & rsp_ch.ready;

    function automatic logic [IDX_W-1:0] offset_of(input logic [IDX_W-1:0] index);
        logic [IDX_W-1:0] rest;
        logic [IDX_W-1:0] sum;
        logic [IDX_W-1:0] coord [DIMS];
        int               n;
        rest = index;
        sum  = '0;
        if (passthrough) begin
            return index;
        end
        n = (dims_in_use > DIMS) ? DIMS : int'(dims_in_use);
        // peel coordinates off from the innermost dimension outward
        for (int d = n - 1; d >= 0; d--) begin
            if (extent_shadow[d] == '0) begin
                coord[d] = rest;
                rest     = '0;
            end else begin
                coord[d] = rest % extent_shadow[d];
                rest     = rest / extent_shadow[d];
            end
        end
        for (int d = 0; d < n; d++) begin
            sum = sum + coord[d] * {16'b0, stride_shadow[d]};
        end
        return sum;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [DIM_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return 32'd1;
            end
            2: begin
                return '1;
            end
            3: begin
                return $urandom;
            end
            default: begin
                return $urandom_range(2, 16);
            end
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_stride();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return $urandom_range(0, 64);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                return '1;
            end
            1: begin
                return '0;
            end
            2, 3: begin
                return IDX_W'($urandom_range(0, 4095));
            end
            4: begin
                return {16'b0, wide[31:0]};
            end
            default: begin
                return wide[IDX_W-1:0];
            end
        endcase
    endfunction

    // Rewrite both registers once every offset in flight has come back.
    task automatic write_setup(input logic [3:0] dims, input logic pass);
        req_ch.valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIM_COUNT;
        i_cfg_data <= dims;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CONTIG;
        i_cfg_data <= CFG_DATA_W'(pass);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dims_in_use = dims;
        passthrough = pass;
        settings_used++;
    endtask

    // Offer one word, hold it until taken, then maybe drop valid for a while.
    task automatic send_word(input logic req, input logic [SEL_W-1:0] sel,
                             input logic [DIM_W-1:0] extent, input logic [DIM_W-1:0] stride,
                             input logic [IDX_W-1:0] index, input logic typed,
                             input logic [IDX_W-1:0] typed_offset, input bit no_gaps);
        int unsigned gap;
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= req;
        req_ch.dim_select   <= sel;
        req_ch.dim_extent   <= extent;
        req_ch.dim_stride   <= stride;
        req_ch.linear_index <= index;
        do @(posedge i_clk); while (!req_ch.ready);
        if (req == REQ_LOAD) begin
            extent_shadow[sel] = extent;
            stride_shadow[sel] = stride;
            loads_sent++;
        end else begin
            pending_offsets.push_back(typed ? typed_offset : offset_of(index));
            translates_sent++;
        end
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.dim_select   <= '0;
        req_ch.dim_extent   <= '0;
        req_ch.dim_stride   <= '0;
        req_ch.linear_index <= '0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_DIM_COUNT;
        i_cfg_data          <= '0;
        i_rst_n             <= 1'b0;
        dims_in_use = 4'd1;
        passthrough = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PROBES[r]) begin
            if (PROBES[r].set_cfg) begin
                write_setup(PROBES[r].dims, PROBES[r].pass);
            end
            send_word(PROBES[r].req, PROBES[r].sel, PROBES[r].extent, PROBES[r].stride,
                      PROBES[r].index, PROBES[r].typed, PROBES[r].offset, 1'b0);
        end

        // every table entry is loaded by now, so any count may be used
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_setup(PHASE_DIMS[p], PHASE_PASS[p]);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                send_word(($urandom_range(0, 9) < 4) ? REQ_LOAD : REQ_XLATE,
                          SEL_W'($urandom_range(0, DIMS - 1)), pick_extent(), pick_stride(),
                          pick_index(), 1'b0, '0, (p % 4) == 2);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d translates across %0d register settings.",
                 loads_sent, translates_sent, settings_used);
        $display("Checked %0d offsets, %0d mismatched.", offsets_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side back-pressure: short stalls mostly, long ones now and then.
    initial begin
        forever begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(200, 800)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            if (pick_gap() != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_fire) begin
            if (pending_offsets.size() == 0) begin
                $display("%0t: offset %h arrived with nothing expected",
                         $time, rsp_ch.element_offset);
                mismatches++;
            end else begin
                want_offset = pending_offsets.pop_front();
                offsets_checked++;
                if (rsp_ch.element_offset !== want_offset) begin
                    $display("%0t: element_offset expected %h, got %h",
                             $time, want_offset, rsp_ch.element_offset);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || req_fire || rsp_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d offsets outstanding",
                     $time, quiet_cycles, pending_offsets.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
